// File: hw/rtl/tbw_pkg.sv
// Shared constants and types for the triangle barycentric weights core.
// Used by tbw_front, tbw_div_cell and the top level.
`default_nettype none

package tbw_pkg;

    // Field formats.
    localparam int COORD_WIDTH      = 16;
    localparam int COORD_FRAC_BITS  = 4;
    localparam int WEIGHT_FRAC_BITS = 16;
    localparam int WEIGHT_WIDTH     = 32;

    // Edge vectors and cross products grow by one bit; products double the width.
    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int MAG_W   = CROSS_W;

    // Dividend is the magnitude scaled up by the weight fraction bits.
    localparam int NUM_W = MAG_W + WEIGHT_FRAC_BITS;

    // Signed sum of 1 - A - B, wide enough to never wrap.
    localparam int SUM_W = NUM_W + 3;

    // Front end has three register stages, the divider one cell per quotient bit,
    // and the output stage one more.
    localparam int LATENCY = 3 + NUM_W + 1;

    // Smallest non-degenerate |z|: 1.0 with twice the coordinate fraction bits.
    localparam logic [MAG_W-1:0] Z_ONE = MAG_W'(1) << (2 * COORD_FRAC_BITS);

    // Fixed-point 1.0 in the weight format.
    localparam logic signed [WEIGHT_WIDTH-1:0] W_ONE =
        WEIGHT_WIDTH'(1) << WEIGHT_FRAC_BITS;
    localparam logic signed [SUM_W-1:0] SUM_ONE = SUM_W'(1) << WEIGHT_FRAC_BITS;

    // Saturation limits, sign-extended to the sum width.
    localparam logic signed [SUM_W-1:0] SUM_MAX =
        {{(SUM_W-WEIGHT_WIDTH+1){1'b0}}, {(WEIGHT_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN =
        {{(SUM_W-WEIGHT_WIDTH+1){1'b1}}, {(WEIGHT_WIDTH-1){1'b0}}};

    // One request as it moves down the divider chain.
    typedef struct packed {
        logic             valid;
        logic             degen;
        logic             neg_a;
        logic             neg_b;
        logic [MAG_W-1:0] den;
        logic [MAG_W-1:0] rem_a;
        logic [MAG_W-1:0] rem_b;
        logic [NUM_W-1:0] work_a;
        logic [NUM_W-1:0] work_b;
    } tbw_div_t;

    // Clamp a wide signed value to the weight width.
    function automatic logic signed [WEIGHT_WIDTH-1:0] sat_weight(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [WEIGHT_WIDTH-1:0] r;
        if (v > SUM_MAX)
        begin
            r = SUM_MAX[WEIGHT_WIDTH-1:0];
        end
        else if (v < SUM_MIN)
        begin
            r = SUM_MIN[WEIGHT_WIDTH-1:0];
        end
        else
        begin
            r = v[WEIGHT_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tbw_front.sv
// Front end: edge vectors, products, cross products and divider setup.
// Depends on tbw_pkg.
`default_nettype none

module tbw_front (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    input  wire logic signed [tbw_pkg::COORD_WIDTH-1:0] vertex0_x,
    input  wire logic signed [tbw_pkg::COORD_WIDTH-1:0] vertex0_y,
    input  wire logic signed [tbw_pkg::COORD_WIDTH-1:0] vertex1_x,
    input  wire logic signed [tbw_pkg::COORD_WIDTH-1:0] vertex1_y,
    input  wire logic signed [tbw_pkg::COORD_WIDTH-1:0] vertex2_x,
    input  wire logic signed [tbw_pkg::COORD_WIDTH-1:0] vertex2_y,
    input  wire logic signed [tbw_pkg::COORD_WIDTH-1:0] point_x,
    input  wire logic signed [tbw_pkg::COORD_WIDTH-1:0] point_y,
    output tbw_pkg::tbw_div_t                           div_out
);
    import tbw_pkg::*;

    logic                     s1_valid_reg;
    logic signed [DIFF_W-1:0] ux_reg, uy_reg, vx_reg, vy_reg, ox_reg, oy_reg;
    logic                     s2_valid_reg;
    logic signed [PROD_W-1:0] vx_oy_reg, ox_vy_reg, ox_uy_reg, ux_oy_reg;
    logic signed [PROD_W-1:0] ux_vy_reg, vx_uy_reg;
    logic signed [CROSS_W-1:0] cx, cy, cz;
    logic [MAG_W-1:0]          mag_x, mag_y, mag_z;
    tbw_div_t                  div_reg, div_next;

    // Stage 1: edge vectors and point offset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        ux_reg <= DIFF_W'(vertex1_x) - DIFF_W'(vertex0_x);
        uy_reg <= DIFF_W'(vertex1_y) - DIFF_W'(vertex0_y);
        vx_reg <= DIFF_W'(vertex2_x) - DIFF_W'(vertex0_x);
        vy_reg <= DIFF_W'(vertex2_y) - DIFF_W'(vertex0_y);
        ox_reg <= DIFF_W'(vertex0_x) - DIFF_W'(point_x);
        oy_reg <= DIFF_W'(vertex0_y) - DIFF_W'(point_y);
    end

    // Stage 2: the six products of the cross product.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        vx_oy_reg <= vx_reg * oy_reg;
        ox_vy_reg <= ox_reg * vy_reg;
        ox_uy_reg <= ox_reg * uy_reg;
        ux_oy_reg <= ux_reg * oy_reg;
        ux_vy_reg <= ux_reg * vy_reg;
        vx_uy_reg <= vx_reg * uy_reg;
    end

    // Stage 3: cross product, magnitudes, quotient signs and degeneracy.
    always_comb
    begin
        cx = CROSS_W'(vx_oy_reg) - CROSS_W'(ox_vy_reg);
        cy = CROSS_W'(ox_uy_reg) - CROSS_W'(ux_oy_reg);
        cz = CROSS_W'(ux_vy_reg) - CROSS_W'(vx_uy_reg);
        mag_x = cx[CROSS_W-1] ? MAG_W'(-cx) : MAG_W'(cx);
        mag_y = cy[CROSS_W-1] ? MAG_W'(-cy) : MAG_W'(cy);
        mag_z = cz[CROSS_W-1] ? MAG_W'(-cz) : MAG_W'(cz);

        div_next.valid  = s2_valid_reg;
        div_next.degen  = (mag_z < Z_ONE);
        div_next.neg_a  = cx[CROSS_W-1] ^ cz[CROSS_W-1];
        div_next.neg_b  = cy[CROSS_W-1] ^ cz[CROSS_W-1];
        div_next.den    = mag_z;
        div_next.rem_a  = '0;
        div_next.rem_b  = '0;
        div_next.work_a = {mag_x, {WEIGHT_FRAC_BITS{1'b0}}};
        div_next.work_b = {mag_y, {WEIGHT_FRAC_BITS{1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg.valid <= 1'b0;
        end
        else
        begin
            div_reg <= div_next;
        end
    end

    assign div_out = div_reg;

endmodule

`default_nettype wire

// File: hw/rtl/tbw_div_cell.sv
// One restoring-division cell: one quotient bit for each of the two lanes.
// Depends on tbw_pkg.
`default_nettype none

module tbw_div_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tbw_pkg::tbw_div_t cell_in,
    output tbw_pkg::tbw_div_t      cell_out
);
    import tbw_pkg::*;

    logic [MAG_W:0] trial_a, trial_b;
    logic           take_a, take_b;
    tbw_div_t       cell_reg, cell_next;

    // Shift in the next dividend bit, subtract when the divisor fits,
    // and shift the quotient bit into the freed low end.
    always_comb
    begin
        trial_a = {cell_in.rem_a, cell_in.work_a[NUM_W-1]};
        trial_b = {cell_in.rem_b, cell_in.work_b[NUM_W-1]};
        take_a  = (trial_a >= {1'b0, cell_in.den});
        take_b  = (trial_b >= {1'b0, cell_in.den});

        cell_next        = cell_in;
        cell_next.rem_a  = take_a ? MAG_W'(trial_a - {1'b0, cell_in.den})
                                  : trial_a[MAG_W-1:0];
        cell_next.rem_b  = take_b ? MAG_W'(trial_b - {1'b0, cell_in.den})
                                  : trial_b[MAG_W-1:0];
        cell_next.work_a = {cell_in.work_a[NUM_W-2:0], take_a};
        cell_next.work_b = {cell_in.work_b[NUM_W-2:0], take_b};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg.valid <= 1'b0;
        end
        else
        begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

`default_nettype wire

// File: hw/rtl/triangle_barycentric_weights_core.sv
// Barycentric weights of a 2D sample point, fixed point; top level.
// Pipeline from start to done: 3 front-end stages, 51 divider cells, 1 output stage.
// Throughput: one request per cycle; busy is always low, the chain of cells is fully pipelined.
// Results appear on done for one cycle each and cannot be stalled.
// Reset (rst_n low, asynchronous) empties the pipeline; no clearing pass is needed.
// Depends on tbw_pkg, tbw_front and tbw_div_cell.
`default_nettype none

module triangle_barycentric_weights_core (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    start,
    output logic                                         busy,
    input  wire logic signed [tbw_pkg::COORD_WIDTH-1:0]  vertex0_x,
    input  wire logic signed [tbw_pkg::COORD_WIDTH-1:0]  vertex0_y,
    input  wire logic signed [tbw_pkg::COORD_WIDTH-1:0]  vertex1_x,
    input  wire logic signed [tbw_pkg::COORD_WIDTH-1:0]  vertex1_y,
    input  wire logic signed [tbw_pkg::COORD_WIDTH-1:0]  vertex2_x,
    input  wire logic signed [tbw_pkg::COORD_WIDTH-1:0]  vertex2_y,
    input  wire logic signed [tbw_pkg::COORD_WIDTH-1:0]  point_x,
    input  wire logic signed [tbw_pkg::COORD_WIDTH-1:0]  point_y,
    output logic                                         done,
    output logic signed [tbw_pkg::WEIGHT_WIDTH-1:0]      weight0,
    output logic signed [tbw_pkg::WEIGHT_WIDTH-1:0]      weight1,
    output logic signed [tbw_pkg::WEIGHT_WIDTH-1:0]      weight2,
    output logic                                         degenerate
);
    import tbw_pkg::*;

    tbw_div_t                        chain [0:NUM_W];
    tbw_div_t                        last;
    logic signed [SUM_W-1:0]         val_a, val_b, val_0;
    logic                            done_reg, done_next;
    logic signed [WEIGHT_WIDTH-1:0]  w0_reg, w1_reg, w2_reg;
    logic signed [WEIGHT_WIDTH-1:0]  w0_next, w1_next, w2_next;
    logic                            degen_reg;

    // The pipeline never holds off a request.
    assign busy = 1'b0;

    // Front end feeds the first cell.
    tbw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .vertex0_x (vertex0_x),
        .vertex0_y (vertex0_y),
        .vertex1_x (vertex1_x),
        .vertex1_y (vertex1_y),
        .vertex2_x (vertex2_x),
        .vertex2_y (vertex2_y),
        .point_x   (point_x),
        .point_y   (point_y),
        .div_out   (chain[0])
    );

    // Row of division cells, one quotient bit per cell.
    for (genvar i = 0; i < NUM_W; i++)
    begin : g_cell
        tbw_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_in  (chain[i]),
            .cell_out (chain[i+1])
        );
    end

    assign last = chain[NUM_W];

    // Signed quotients, the first weight, saturation, and the fixed degenerate pattern.
    always_comb
    begin
        val_a = last.neg_a ? -$signed({3'b000, last.work_a})
                           :  $signed({3'b000, last.work_a});
        val_b = last.neg_b ? -$signed({3'b000, last.work_b})
                           :  $signed({3'b000, last.work_b});
        val_0 = SUM_ONE - val_a - val_b;
        done_next = last.valid;
        if (last.degen)
        begin
            w0_next = -W_ONE;
            w1_next = W_ONE;
            w2_next = W_ONE;
        end
        else
        begin
            w0_next = sat_weight(val_0);
            w1_next = sat_weight(val_a);
            w2_next = sat_weight(val_b);
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w0_reg    <= w0_next;
        w1_reg    <= w1_next;
        w2_reg    <= w2_next;
        degen_reg <= last.degen;
    end

    assign done       = done_reg;
    assign weight0    = w0_reg;
    assign weight1    = w1_reg;
    assign weight2    = w2_reg;
    assign degenerate = degen_reg;

    // Every accepted request comes out after the fixed latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done)
        else $error("request did not complete after the pipeline latency");

    // A degenerate result carries the fixed weight pattern.
    a_degen_weights: assert property (@(posedge clk) disable iff (!rst_n)
        (done && degenerate) |-> (weight0 == -W_ONE && weight1 == W_ONE
                                  && weight2 == W_ONE))
        else $error("degenerate result has wrong weights");

    // A result strobe needs a request that entered one latency earlier.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(done) && $past(rst_n, LATENCY)) |-> $past(start, LATENCY))
        else $error("result without a matching request");

endmodule

`default_nettype wire
